@@ rtl/xcs_pkg.sv @@
// Shared types and protocol constants for the XMODEM checksum sender.
package xcs_pkg;

   // Input transaction payload.
   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_byte;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [2:0] event_res;
      logic [2:0] phase;
   } rsp_type;

   // Operation codes.
   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1;
   localparam logic [2:0] OP_RXBYTE = 3'd2;
   localparam logic [2:0] OP_TXSLOT = 3'd3;
   localparam logic [2:0] OP_FINISH = 3'd4;

   // Line symbols.
   localparam logic [7:0] SYM_SOH = 8'h01;
   localparam logic [7:0] SYM_EOT = 8'h04;
   localparam logic [7:0] SYM_ACK = 8'h06;
   localparam logic [7:0] SYM_NAK = 8'h15;
   localparam logic [7:0] SYM_CAN = 8'h18;
   localparam logic [7:0] NUM_COMPLEMENT_BASE = 8'hFF;

   // Protocol phases.
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_WAIT_NAK   = 3'd1;
   localparam logic [2:0] PH_LOAD       = 3'd2;
   localparam logic [2:0] PH_SEND       = 3'd3;
   localparam logic [2:0] PH_WAIT_REPLY = 3'd4;
   localparam logic [2:0] PH_SEND_EOT   = 3'd5;
   localparam logic [2:0] PH_WAIT_EOT   = 3'd6;

   // Reported events.
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_READY     = 3'd1;
   localparam logic [2:0] EV_ACKED     = 3'd2;
   localparam logic [2:0] EV_DONE      = 3'd3;
   localparam logic [2:0] EV_CANCEL    = 3'd4;
   localparam logic [2:0] EV_EXHAUSTED = 3'd5;

   // Retry register reset value and attempt counter ceiling.
   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd10;
   localparam logic [3:0] ATTEMPTS_MAX      = 4'd15;

endpackage

@@ rtl/xcs_block_ram.sv @@
// Block buffer memory: one write port and one registered read port.
module xcs_block_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/xmodem_checksum_sender.sv @@
// Top level of the XMODEM checksum sender: protocol state, frame sequencing, output stage.
//
// Usage: the req_ channel carries one operation per transaction (start,
// load a data byte, a byte received from the far end, a transmit slot, or
// finish). Every accepted transaction yields exactly one rsp_ transaction
// telling whether a byte is to be sent in this slot, which byte, any
// protocol event, and the phase after the operation.
// Throughput is one transaction per cycle while rsp_ready stays high. The protocol
// state, the block buffer read and the middle stage are updated at the accepting
// edge; the output stage registers the result once it is free or draining. The
// buffer is a single-port-write, registered-read memory of BLOCK_BYTES entries.
// The retry limit, written through csr_wr_en/csr_wr_data, resets to 10; the user
// must write it only while no transaction is in flight (the block does not enforce it).
// Reset (synchronous, active high) returns the block to idle with no
// result pending. When the receiver holds rsp_ready low, the result stays
// on rsp_data, one more transaction is taken into the middle stage, and
// req_ready then drops until the output drains.
module xmodem_checksum_sender #(
   parameter int BLOCK_BYTES = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  xcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output xcs_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [3:0]       csr_wr_data
);
   import xcs_pkg::*;

   localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam int POS_W = $clog2(BLOCK_BYTES + 4);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BYTES + 3);
   localparam logic [POS_W-1:0] POS_DATA = POS_W'(3);

   // Protocol state.
   logic [2:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] load_index_ff, load_index_in;
   logic [7:0]       checksum_ff, checksum_in;
   logic [7:0]       block_number_ff, block_number_in;
   logic [POS_W-1:0] send_pos_ff, send_pos_in;
   logic [3:0]       attempts_ff, attempts_in;
   logic [3:0]       retry_limit_ff;

   // Middle stage and output stage.
   logic       s1_valid_ff;
   logic       s1_tx_valid_ff, s1_tx_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_use_mem_ff, s1_use_mem_in;
   logic [2:0] s1_event_ff, s1_event_in;
   logic [2:0] s1_phase_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   logic             accept;
   logic             s1_advance;
   logic             mem_wr_en;
   logic [IDX_W-1:0] data_pos;
   logic [7:0]       mem_rd_data;

   // Handshake: the middle stage moves on whenever the output is free or draining.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign mem_wr_en = accept && (req_data.operation == OP_LOAD) && (phase_ff == PH_LOAD);
   assign data_pos  = IDX_W'(send_pos_ff - POS_DATA);

   xcs_block_ram #(
      .DEPTH  (BLOCK_BYTES),
      .ADDR_W (IDX_W)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (load_index_ff),
      .wr_data (req_data.data_byte),
      .rd_en   (accept),
      .rd_addr (data_pos),
      .rd_data (mem_rd_data)
   );

   // Next protocol state and the raw result of one transaction.
   always_comb begin
      phase_in        = phase_ff;
      load_index_in   = load_index_ff;
      checksum_in     = checksum_ff;
      block_number_in = block_number_ff;
      send_pos_in     = send_pos_ff;
      attempts_in     = attempts_ff;
      s1_tx_valid_in  = 1'b0;
      s1_byte_in      = 8'h00;
      s1_use_mem_in   = 1'b0;
      s1_event_in     = EV_NONE;

      unique case (req_data.operation)
         OP_START: begin
            block_number_in = 8'h00;
            load_index_in   = '0;
            checksum_in     = 8'h00;
            send_pos_in     = '0;
            attempts_in     = 4'd0;
            phase_in        = PH_WAIT_NAK;
         end
         OP_LOAD: begin
            if (phase_ff == PH_LOAD) begin
               checksum_in   = checksum_ff + req_data.data_byte;
               load_index_in = load_index_ff + IDX_W'(1);
               if (load_index_ff == LAST_IDX) begin
                  block_number_in = block_number_ff + 8'd1;
                  send_pos_in     = '0;
                  attempts_in     = 4'd0;
                  phase_in        = PH_SEND;
               end
            end
         end
         OP_RXBYTE: begin
            if (phase_ff == PH_WAIT_NAK) begin
               if (req_data.data_byte == SYM_NAK) begin
                  load_index_in = '0;
                  checksum_in   = 8'h00;
                  phase_in      = PH_LOAD;
                  s1_event_in   = EV_READY;
               end else if (req_data.data_byte == SYM_CAN) begin
                  phase_in    = PH_IDLE;
                  s1_event_in = EV_CANCEL;
               end
            end else if (phase_ff == PH_WAIT_REPLY) begin
               if (req_data.data_byte == SYM_ACK) begin
                  load_index_in = '0;
                  checksum_in   = 8'h00;
                  phase_in      = PH_LOAD;
                  s1_event_in   = EV_ACKED;
               end else if (req_data.data_byte == SYM_CAN) begin
                  phase_in    = PH_IDLE;
                  s1_event_in = EV_CANCEL;
               end else if (req_data.data_byte == SYM_NAK) begin
                  if (attempts_ff < retry_limit_ff) begin
                     send_pos_in = '0;
                     phase_in    = PH_SEND;
                  end else begin
                     phase_in    = PH_IDLE;
                     s1_event_in = EV_EXHAUSTED;
                  end
               end
            end else if (phase_ff == PH_WAIT_EOT) begin
               if (req_data.data_byte == SYM_ACK) begin
                  phase_in    = PH_IDLE;
                  s1_event_in = EV_DONE;
               end else if (req_data.data_byte == SYM_CAN) begin
                  phase_in    = PH_IDLE;
                  s1_event_in = EV_CANCEL;
               end
            end
         end
         OP_TXSLOT: begin
            if (phase_ff == PH_SEND) begin
               s1_tx_valid_in = 1'b1;
               // Frame order: header, block number, its complement, data, checksum.
               priority if (send_pos_ff == POS_W'(0)) begin
                  s1_byte_in = SYM_SOH;
               end else if (send_pos_ff == POS_W'(1)) begin
                  s1_byte_in = block_number_ff;
               end else if (send_pos_ff == POS_W'(2)) begin
                  s1_byte_in = NUM_COMPLEMENT_BASE - block_number_ff;
               end else if (send_pos_ff == LAST_POS) begin
                  s1_byte_in = checksum_ff;
               end else begin
                  s1_use_mem_in = 1'b1;
               end
               if (send_pos_ff == LAST_POS) begin
                  send_pos_in = '0;
                  if (attempts_ff < ATTEMPTS_MAX) begin
                     attempts_in = attempts_ff + 4'd1;
                  end
                  phase_in = PH_WAIT_REPLY;
               end else begin
                  send_pos_in = send_pos_ff + POS_W'(1);
               end
            end else if (phase_ff == PH_SEND_EOT) begin
               s1_tx_valid_in = 1'b1;
               s1_byte_in     = SYM_EOT;
               phase_in       = PH_WAIT_EOT;
            end
         end
         OP_FINISH: begin
            if (phase_ff == PH_LOAD) begin
               load_index_in = '0;
               checksum_in   = 8'h00;
               phase_in      = PH_SEND_EOT;
            end
         end
         default: begin
         end
      endcase
   end

   // Protocol state registers, updated once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         load_index_ff   <= '0;
         checksum_ff     <= 8'h00;
         block_number_ff <= 8'h00;
         send_pos_ff     <= '0;
         attempts_ff     <= 4'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         load_index_ff   <= load_index_in;
         checksum_ff     <= checksum_in;
         block_number_ff <= block_number_in;
         send_pos_ff     <= send_pos_in;
         attempts_ff     <= attempts_in;
      end
   end

   // Retry limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         retry_limit_ff <= csr_wr_data;
      end
   end

   // Middle stage: holds the result while the buffer read completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tx_valid_ff <= s1_tx_valid_in;
         s1_byte_ff     <= s1_byte_in;
         s1_use_mem_ff  <= s1_use_mem_in;
         s1_event_ff    <= s1_event_in;
         s1_phase_ff    <= phase_in;
      end
   end

   // Output stage: holds the result until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff.tx_valid  <= s1_tx_valid_ff;
         rsp_data_ff.tx_byte   <= s1_use_mem_ff ? mem_rd_data : s1_byte_ff;
         rsp_data_ff.event_res <= s1_event_ff;
         rsp_data_ff.phase     <= s1_phase_ff;
      end
   end

endmodule
